FILE: rtl/core/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned LINE_LENGTH = 76;
  localparam int unsigned LINE_W      = 7;
  localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(LINE_LENGTH);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BREAK_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_URL_ALPHABET      = 2'd2;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  typedef struct packed {
    logic [23:0] grp;
    logic [2:0]  n_data;
    logic [1:0]  n_pad;
    logic        crlf;
    logic        msg_last;
    logic        url;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = url ? 8'h2D : 8'h2B;
    end else begin
      c = url ? 8'h5F : 8'h2F;
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/b64e_front.sv
module b64e_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [b64e_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                            cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  input  logic                            q_full,
  output logic                            q_push,
  output b64e_pkg::job_t                  q_job
);

  logic                            pad_r, lbe_r, url_r;
  logic [15:0]                     pend_r, pend_nxt;
  logic [1:0]                      cnt_r, cnt_nxt;
  logic [b64e_pkg::LINE_W-1:0]     line_r, line_nxt, line_add;
  logic                            accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign line_add  = line_r + b64e_pkg::LINE_W'(4);

  always_comb begin
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    line_nxt       = line_r;
    q_push         = 1'b0;
    q_job.grp      = {pend_r, in_tdata};
    q_job.n_data   = 3'd4;
    q_job.n_pad    = 2'd0;
    q_job.crlf     = 1'b0;
    q_job.msg_last = in_tlast;
    q_job.url      = url_r;
    if (accept) begin
      if (cnt_r == 2'd2) begin
        q_push   = 1'b1;
        pend_nxt = '0;
        cnt_nxt  = 2'd0;
        if (lbe_r) begin
          if (line_add >= b64e_pkg::LINE_LIMIT) begin
            q_job.crlf = 1'b1;
            line_nxt   = '0;
          end else begin
            line_nxt = line_add;
          end
        end
      end else begin
        pend_nxt = {pend_r[7:0], in_tdata};
        cnt_nxt  = cnt_r + 2'd1;
        if (in_tlast) begin
          q_push = 1'b1;
          if (cnt_r == 2'd0) begin
            q_job.grp    = {in_tdata, 16'h0000};
            q_job.n_data = 3'd2;
            q_job.n_pad  = pad_r ? 2'd2 : 2'd0;
          end else begin
            q_job.grp    = {pend_r[7:0], in_tdata, 8'h00};
            q_job.n_data = 3'd3;
            q_job.n_pad  = pad_r ? 2'd1 : 2'd0;
          end
        end
      end
      if (in_tlast) begin
        pend_nxt = '0;
        cnt_nxt  = 2'd0;
        line_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r  <= 1'b1;
      lbe_r  <= 1'b0;
      url_r  <= 1'b0;
      pend_r <= '0;
      cnt_r  <= 2'd0;
      line_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      line_r <= line_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          b64e_pkg::CFG_PAD_ENABLE:        pad_r <= cfg_data;
          b64e_pkg::CFG_LINE_BREAK_ENABLE: lbe_r <= cfg_data;
          b64e_pkg::CFG_URL_ALPHABET:      url_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/b64e_queue.sv
module b64e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output b64e_pkg::job_t rd_job
);

  b64e_pkg::job_t                slots_r [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::QAW:0]        count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full     = count_r == (b64e_pkg::QAW+1)'(b64e_pkg::QDEPTH);
  assign rd_valid = count_r != '0;
  assign rd_job   = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/b64e_back.sv
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  b64e_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       end_r, end_nxt;
  logic       load, final_char;
  logic [2:0] total, data_pad;
  logic [5:0] six;

  assign load       = !valid_r || out_tready;
  assign data_pad   = q_job.n_data + {1'b0, q_job.n_pad};
  assign total      = data_pad + {1'b0, q_job.crlf, 1'b0};
  assign final_char = idx_r == (total - 3'd1);
  assign q_pop      = load && q_valid && final_char;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    six = q_job.grp[23:18];
      2'd1:    six = q_job.grp[17:12];
      2'd2:    six = q_job.grp[11:6];
      default: six = q_job.grp[5:0];
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    end_nxt   = end_r;
    if (load) begin
      valid_nxt = q_valid;
      if (q_valid) begin
        if (idx_r < q_job.n_data) begin
          char_nxt = b64e_pkg::sextet_char(six, q_job.url);
        end else if (idx_r < data_pad) begin
          char_nxt = b64e_pkg::CHAR_PAD;
        end else if (idx_r == data_pad) begin
          char_nxt = b64e_pkg::CHAR_CR;
        end else begin
          char_nxt = b64e_pkg::CHAR_LF;
        end
        last_nxt = final_char;
        end_nxt  = final_char && q_job.msg_last;
        idx_nxt  = final_char ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    char_r <= char_nxt;
    last_r <= last_nxt;
    end_r  <= end_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;
  assign out_tlast  = last_r;
  assign out_tuser  = end_r;

endmodule

FILE: rtl/core/base64_stream_encoder.sv
// Base64 stream encoder.
// Input channel: one source byte per item on in_tdata, in_tlast marks the
// last byte of a message. Output channel: one ASCII character per item on
// out_tdata; out_tlast marks the last character caused by an input byte,
// out_tuser marks the final character of the encoded message.
// Configuration: cfg_index 0 pad enable, 1 line break enable (CR LF after
// 76 characters), 2 URL-safe alphabet; other indexes are ignored.
// Path: a byte that completes a group is written into the job queue, and its
// first character is then loaded into the registered output stage.
// Flow: the output stage emits one character per cycle while out_tready is
// high; a full group of three bytes gives four characters (six with CR LF).
// Bytes that complete no group are accepted back to back while the
// four-entry job queue has room.
// Reset: pad enable set, line breaks and URL alphabet cleared, partial group
// and line count cleared, queue and output stage empty.
// Stall: while out_tready is low the output character holds; the queue fills
// and in_tready drops once four jobs are waiting.
module base64_stream_encoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [b64e_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_char
  output logic                           out_tlast,
  output logic                           out_tuser   // [0] message_end
);

  logic           q_full, q_push, q_pop, q_valid;
  b64e_pkg::job_t wr_job, rd_job;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (wr_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_job   (wr_job),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_job   (rd_job)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (rd_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import b64e_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned RANDOM_BYTES = 330;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [8*64-1:0] STD_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [8*64-1:0] URL_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       msg_end;
  } enc_char_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  localparam logic [2:0] USE_MODEL = 3'd7;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  val;
    logic        flag;
    logic [2:0]  gold_n;
    logic [47:0] gold;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 31;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_BYTE, 8'h00, 1'b1, 3'd4, 48'("AA==")},
    '{ROW_BYTE, 8'hFF, 1'b1, 3'd4, 48'("/w==")},
    '{ROW_BYTE, 8'hFF, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFF, 1'b1, 3'd4, 48'("//8=")},
    '{ROW_BYTE, 8'hFF, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFF, 1'b1, 3'd4, 48'("////")},
    '{ROW_BYTE, 8'h00, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'h00, 1'b0, 3'd4, 48'("AAAA")},
    '{ROW_BYTE, 8'hFB, 1'b1, 3'd4, 48'("+w==")},
    '{ROW_BYTE, 8'h4D, 1'b0, USE_MODEL, 48'd0},
    '{ROW_BYTE, 8'h61, 1'b0, USE_MODEL, 48'd0},
    '{ROW_BYTE, 8'h6E, 1'b1, USE_MODEL, 48'd0},
    '{ROW_REG, {6'd0, CFG_URL_ALPHABET}, 1'b1, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFB, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFF, 1'b1, 3'd4, 48'("-_8=")},
    '{ROW_REG, {6'd0, CFG_PAD_ENABLE}, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFB, 1'b1, 3'd2, 48'("-w")},
    '{ROW_REG, {6'd0, CFG_UNUSED_IDX}, 1'b1, 3'd0, 48'd0},
    '{ROW_BYTE, 8'h00, 1'b1, 3'd2, 48'("AA")},
    '{ROW_REG, {6'd0, CFG_PAD_ENABLE}, 1'b1, 3'd0, 48'd0},
    '{ROW_REG, {6'd0, CFG_URL_ALPHABET}, 1'b0, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFF, 1'b0, 3'd0, 48'd0},
    '{ROW_REG, {6'd0, CFG_URL_ALPHABET}, 1'b1, 3'd0, 48'd0},
    '{ROW_BYTE, 8'hFF, 1'b1, 3'd4, 48'("__8=")},
    '{ROW_REG, {6'd0, CFG_URL_ALPHABET}, 1'b0, 3'd0, 48'd0},
    '{ROW_REG, {6'd0, CFG_LINE_BREAK_ENABLE}, 1'b1, 3'd0, 48'd0},
    '{ROW_BYTE, 8'h12, 1'b0, USE_MODEL, 48'd0},
    '{ROW_BYTE, 8'h34, 1'b0, USE_MODEL, 48'd0},
    '{ROW_BYTE, 8'h56, 1'b1, USE_MODEL, 48'd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;

  base64_stream_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  logic        pad_en;
  logic        brk_en;
  logic        url_en;
  logic [15:0] held_bytes;
  logic [1:0]  held_cnt;
  logic [6:0]  line_cnt;

  logic [7:0]  enc_chars [0:5];
  int          enc_n;
  enc_char_t   char_fifo [$];

  int          mismatches;
  logic        in_idle_on;
  logic        out_stall_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] v, input logic url);
    return url ? URL_SET[8*(63-v) +: 8] : STD_SET[8*(63-v) +: 8];
  endfunction

  task automatic add_char(input logic [7:0] c);
    enc_chars[enc_n] = c;
    enc_n = enc_n + 1;
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic [23:0] grp;
    enc_n = 0;
    if (held_cnt >= 2'd2) begin
      grp = {held_bytes, b};
      for (int k = 0; k < 4; k++) add_char(b64_char(grp[23-6*k -: 6], url_en));
      held_bytes = 16'd0;
      held_cnt = 2'd0;
      if (brk_en) begin
        line_cnt = line_cnt + 7'd4;
        if (line_cnt >= LINE_LIMIT) begin
          add_char(CHAR_CR);
          add_char(CHAR_LF);
          line_cnt = 7'd0;
        end
      end
    end else begin
      held_bytes = {held_bytes[7:0], b};
      held_cnt = held_cnt + 2'd1;
      if (lst) begin
        if (held_cnt == 2'd1) begin
          grp = {held_bytes[7:0], 16'd0};
          add_char(b64_char(grp[23:18], url_en));
          add_char(b64_char(grp[17:12], url_en));
          if (pad_en) begin
            add_char(CHAR_PAD);
            add_char(CHAR_PAD);
          end
        end else begin
          grp = {held_bytes, 8'd0};
          add_char(b64_char(grp[23:18], url_en));
          add_char(b64_char(grp[17:12], url_en));
          add_char(b64_char(grp[11:6], url_en));
          if (pad_en) add_char(CHAR_PAD);
        end
      end
    end
    if (lst) begin
      held_bytes = 16'd0;
      held_cnt = 2'd0;
      line_cnt = 7'd0;
    end
  endtask

  task automatic queue_chars(input logic lst);
    for (int k = 0; k < enc_n; k++)
      char_fifo.push_back('{enc_chars[k], k == enc_n - 1, (k == enc_n - 1) && lst});
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [2:0] gold_n,
                           input logic [47:0] gold);
    while (in_idle_on && $urandom_range(99) < 7) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    encode_byte(b, lst);
    if (gold_n != USE_MODEL) begin
      enc_n = gold_n;
      for (int k = 0; k < gold_n; k++) enc_chars[k] = gold[8*(gold_n-1-k) +: 8];
    end
    queue_chars(lst);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (char_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PAD_ENABLE:        pad_en = val;
      CFG_LINE_BREAK_ENABLE: brk_en = val;
      CFG_URL_ALPHABET:      url_en = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= !(out_stall_on && $urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    enc_char_t want;
    enc_char_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tlast, out_tuser};
      if (char_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: char %h last %b end %b", got.ch, got.run_last,
                   got.msg_end);
      end else begin
        want = char_fifo.pop_front();
        if (got.ch !== want.ch || got.run_last !== want.run_last ||
            got.msg_end !== want.msg_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected char %h last %b end %b, got char %h last %b end %b",
                     want.ch, want.run_last, want.msg_end, got.ch, got.run_last,
                     got.msg_end);
        end
      end
    end
  end

  initial begin
    #4800000;
    $display("** base64_stream_encoder: FAILED **");
    $finish;
  end

  initial begin
    int sent;
    int phase;
    int len;
    int msgs;
    logic lst;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_PAD_ENABLE;
    cfg_data     = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'd0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    mismatches   = 0;
    pad_en       = 1'b1;
    brk_en       = 1'b0;
    url_en       = 1'b0;
    held_bytes   = 16'd0;
    held_cnt     = 2'd0;
    line_cnt     = 7'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_REG) begin
        drain();
        write_reg(DIR_TABLE[r].val[CFG_IDX_W-1:0], DIR_TABLE[r].flag);
      end else begin
        send_byte(DIR_TABLE[r].val, DIR_TABLE[r].flag, DIR_TABLE[r].gold_n,
                  DIR_TABLE[r].gold);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      drain();
      in_idle_on   = !(phase == 2 || phase == 3);
      out_stall_on = !(phase == 2 || phase == 3);
      write_reg(CFG_PAD_ENABLE, phase == 0 ? 1'b1 : 1'($urandom_range(1)));
      write_reg(CFG_LINE_BREAK_ENABLE, phase < 2 ? 1'b1 : 1'($urandom_range(1)));
      write_reg(CFG_URL_ALPHABET, 1'($urandom_range(1)));
      msgs = $urandom_range(2, 5);
      for (int m = 0; m < msgs; m++) begin
        len = $urandom_range(99);
        if (phase == 0 && m == 0) len = 57;
        else if (len < 12) len = $urandom_range(55, 60);
        else if (len < 15) len = $urandom_range(112, 118);
        else len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          lst = (i == len - 1);
          send_byte(8'($urandom_range(255)), lst, USE_MODEL, 48'd0);
          sent++;
          if (!lst && $urandom_range(99) < 2) begin
            drain();
            write_reg(CFG_IDX_W'($urandom_range(3)), 1'($urandom_range(1)));
          end
        end
      end
      phase++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (char_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** base64_stream_encoder: PASSED **");
    end else begin
      $display("** base64_stream_encoder: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
verif/tb_top.sv
